// ===== hdl/utd_pkg.sv =====
// ----------------------------------------------------------------------------
// UTF-8 decoder package
// Shared types and byte constants for the UTF-8 to code point decoder.
// ----------------------------------------------------------------------------
package utd_pkg;

	localparam int CP_W        = 31;
	localparam int BYTE_W      = 8;
	localparam int REMAIN_W    = 3;
	localparam int RES_DEPTH   = 4;
	localparam int RES_PTR_W   = $clog2(RES_DEPTH);
	localparam int RES_CNT_W   = $clog2(RES_DEPTH + 1);

	localparam logic [BYTE_W-1:0] BYTE_NUL       = 8'h00;
	localparam logic [BYTE_W-1:0] BYTE_CONT_LO   = 8'h80;
	localparam logic [BYTE_W-1:0] BYTE_CONT_HI   = 8'hBF;
	localparam logic [BYTE_W-1:0] BYTE_LEAD2_LO  = 8'hC0;
	localparam logic [BYTE_W-1:0] BYTE_LEAD3_LO  = 8'hE0;
	localparam logic [BYTE_W-1:0] BYTE_LEAD4_LO  = 8'hF0;
	localparam logic [BYTE_W-1:0] BYTE_LEAD5_LO  = 8'hF8;
	localparam logic [BYTE_W-1:0] BYTE_LEAD6_LO  = 8'hFC;
	localparam logic [BYTE_W-1:0] BYTE_LEAD_MAX  = 8'hFD;

	typedef enum logic [1:0] {
		MODE_IDLE = 2'd0,
		MODE_SEQ  = 2'd1,
		MODE_HALT = 2'd2
	} decode_mode_t;

	typedef struct packed {
		logic [CP_W-1:0] code_point;
		logic            malformed;
		logic            end_of_string;
		logic            stopped_early;
	} result_t;

	// Results produced by one decode step: zero, one or two
	typedef struct packed {
		logic [1:0] num;
		result_t    r0;
		result_t    r1;
	} push_t;

	typedef struct packed {
		logic [RES_CNT_W-1:0] count;
		logic                 room2;
	} fifo_status_t;

endpackage

// ===== hdl/utd_decode.sv =====
// ----------------------------------------------------------------------------
// UTF-8 decode step
// Holds the sequence state and turns one byte into zero, one or two results.
// ----------------------------------------------------------------------------
module utd_decode
	import utd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [BYTE_W-1:0] in_byte,
	output push_t             push
);

	decode_mode_t         mode_q, mode_d;
	logic [REMAIN_W-1:0]  remain_q, remain_d;
	logic [CP_W-1:0]      acc_q, acc_d;

	logic                 is_nul;
	logic                 is_cont;
	logic [CP_W-1:0]      acc_shift;
	logic [REMAIN_W-1:0]  remain_dec;
	push_t                push_raw;

	assign is_nul     = (in_byte == BYTE_NUL);
	assign is_cont    = (in_byte >= BYTE_CONT_LO) && (in_byte <= BYTE_CONT_HI);
	assign acc_shift  = {acc_q[CP_W-7:0], in_byte[5:0]};
	assign remain_dec = remain_q - REMAIN_W'(1);

	always_comb begin
		mode_d   = mode_q;
		remain_d = remain_q;
		acc_d    = acc_q;
		push_raw = '0;
		case (mode_q)
			MODE_HALT: begin
				// drop everything up to the terminator
				if (is_nul) begin
					push_raw.num              = 2'd1;
					push_raw.r0.end_of_string = 1'b1;
					push_raw.r0.stopped_early = 1'b1;
					mode_d                    = MODE_IDLE;
				end
			end
			MODE_SEQ: begin
				if (is_nul) begin
					push_raw.num              = 2'd2;
					push_raw.r0.code_point    = acc_q;
					push_raw.r0.malformed     = 1'b1;
					push_raw.r1.end_of_string = 1'b1;
					mode_d                    = MODE_IDLE;
				end else if (is_cont) begin
					acc_d    = acc_shift;
					remain_d = remain_dec;
					if (remain_dec == '0) begin
						push_raw.num           = 2'd1;
						push_raw.r0.code_point = acc_shift;
						mode_d                 = MODE_IDLE;
					end
				end else begin
					push_raw.num           = 2'd1;
					push_raw.r0.code_point = acc_q;
					push_raw.r0.malformed  = 1'b1;
					mode_d                 = MODE_IDLE;
					remain_d               = '0;
				end
			end
			default: begin
				mode_d = MODE_IDLE;
				if (is_nul) begin
					push_raw.num              = 2'd1;
					push_raw.r0.end_of_string = 1'b1;
				end else if (in_byte < BYTE_CONT_LO) begin
					push_raw.num           = 2'd1;
					push_raw.r0.code_point = CP_W'(in_byte);
				end else if (in_byte < BYTE_LEAD2_LO || in_byte > BYTE_LEAD_MAX) begin
					mode_d = MODE_HALT;
				end else begin
					mode_d = MODE_SEQ;
					if (in_byte < BYTE_LEAD3_LO) begin
						acc_d    = CP_W'(in_byte[4:0]);
						remain_d = REMAIN_W'(1);
					end else if (in_byte < BYTE_LEAD4_LO) begin
						acc_d    = CP_W'(in_byte[3:0]);
						remain_d = REMAIN_W'(2);
					end else if (in_byte < BYTE_LEAD5_LO) begin
						acc_d    = CP_W'(in_byte[2:0]);
						remain_d = REMAIN_W'(3);
					end else if (in_byte < BYTE_LEAD6_LO) begin
						acc_d    = CP_W'(in_byte[1:0]);
						remain_d = REMAIN_W'(4);
					end else begin
						acc_d    = CP_W'(in_byte[0]);
						remain_d = REMAIN_W'(5);
					end
				end
			end
		endcase
	end

	always_comb begin
		push = push_raw;
		if (!step) begin
			push.num = 2'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_IDLE;
			remain_q <= '0;
			acc_q    <= '0;
		end else if (step) begin
			mode_q   <= mode_d;
			remain_q <= remain_d;
			acc_q    <= acc_d;
		end
	end

endmodule

// ===== hdl/utd_result_fifo.sv =====
// ----------------------------------------------------------------------------
// UTF-8 decoder result queue
// Small queue that takes up to two results a cycle and hands out one.
// ----------------------------------------------------------------------------
module utd_result_fifo
	import utd_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  push_t        push,
	output logic         out_valid,
	input  logic         out_ready,
	output result_t      head,
	output fifo_status_t status
);

	result_t               entry_q [RES_DEPTH];
	logic [RES_PTR_W-1:0]  wr_q;
	logic [RES_PTR_W-1:0]  rd_q;
	logic [RES_CNT_W-1:0]  count_q;
	logic                  pop;
	logic [RES_PTR_W-1:0]  wr_next1;

	assign out_valid    = (count_q != '0);
	assign pop          = out_valid && out_ready;
	assign head         = entry_q[rd_q];
	assign wr_next1     = wr_q + RES_PTR_W'(1);
	assign status.count = count_q;
	assign status.room2 = (count_q <= RES_CNT_W'(RES_DEPTH - 2));

	always_ff @(posedge clk) begin
		if (push.num != 2'd0) begin
			entry_q[wr_q] <= push.r0;
		end
		if (push.num == 2'd2) begin
			entry_q[wr_next1] <= push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + RES_PTR_W'(push.num);
			if (pop) begin
				rd_q <= rd_q + RES_PTR_W'(1);
			end
			count_q <= count_q + RES_CNT_W'(push.num) - RES_CNT_W'(pop);
		end
	end

endmodule

// ===== hdl/utf8_to_codepoint_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// UTF-8 to code point decoder
// Byte-serial decoder of zero-terminated UTF-8 strings into 31-bit code points.
// ----------------------------------------------------------------------------
// One byte is accepted per transaction, and a new byte can be taken every
// cycle. Each byte is held in an input register, decoded there by a single
// pass of compare, mask and shift logic, and its results are pushed into a
// four-entry result queue that drives the output ports. A byte yields zero,
// one or two results; the only two-result case is a terminator arriving
// inside a multibyte sequence, which gives the partial code point flagged
// malformed followed by the end marker. The results of a byte are written
// into the queue as the byte advances out of the input register, and the
// output is driven from the queue head. A held byte advances only when
// the queue has room for two results, that is when it holds two or fewer;
// with the output drained every cycle the queue never holds more than two,
// and the decoder sustains one byte per clock. A stalled output lets the
// queue climb past two results, and then the input stage holds its byte and
// drops ready. The original 1 to 6 byte lead forms are accepted. A bad lead
// byte halts the string: later bytes are dropped and the end marker carries
// stopped_early. A bad continuation byte is consumed and ends the sequence
// with a malformed result.
// ----------------------------------------------------------------------------
module utf8_to_codepoint_decoder_unit
	import utd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [BYTE_W-1:0] in_byte,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [CP_W-1:0]   code_point,
	output logic              malformed,
	output logic              end_of_string,
	output logic              stopped_early
);

	// input register stage
	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;

	logic              advance;
	logic              in_fire;
	push_t             push;
	result_t           head;
	fifo_status_t      fifo_status;

	// Advance the held byte into the decoder when the queue can take the
	// worst case of two results from it.
	assign advance  = valid_s1 && fifo_status.room2;
	assign in_ready = !valid_s1 || fifo_status.room2;
	assign in_fire  = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// payload: capture on every accepted transaction, no reset needed
	always_ff @(posedge clk) begin
		if (in_fire) begin
			byte_s1 <= in_byte;
		end
	end

	utd_decode u_decode (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.in_byte (byte_s1),
		.push    (push)
	);

	utd_result_fifo u_result_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.head      (head),
		.status    (fifo_status)
	);

	assign code_point    = head.code_point;
	assign malformed     = head.malformed;
	assign end_of_string = head.end_of_string;
	assign stopped_early = head.stopped_early;

	// queue never overfills
	a_fifo_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fifo_status.count <= RES_CNT_W'(RES_DEPTH))
		else $error("result queue count exceeds its depth");

	// a pair of results is always a malformed partial followed by the end marker
	a_pair_shape: assert property (@(posedge clk) disable iff (!arst_n)
		push.num == 2'd2 |-> push.r0.malformed && push.r1.end_of_string
			&& !push.r0.end_of_string)
		else $error("two-result step with unexpected result shape");

	// results are pushed only when the held byte advances
	a_push_on_advance: assert property (@(posedge clk) disable iff (!arst_n)
		push.num != 2'd0 |-> advance)
		else $error("result pushed without a byte advancing");

	// a byte that advances without a new one arriving leaves the input stage empty
	a_stage_drains: assert property (@(posedge clk) disable iff (!arst_n)
		advance && !in_fire |=> !valid_s1)
		else $error("input stage held a byte after it advanced");

	// stopped flag appears only on an end marker carrying no code point
	a_stop_on_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && stopped_early |-> end_of_string && code_point == '0)
		else $error("stopped flag on a result that is not an empty end marker");

endmodule

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// UTF-8 decoder testbench
// Streams zero-terminated UTF-8 strings into the decoder and checks each
// decoded code point, malformed flag and end marker against a byte-level
// predictor. A directed opener covers the edge encodings and error paths, then
// random strings run under random gaps, a gap-free stretch and one long
// output hold-off.
// ----------------------------------------------------------------------------
module tb
	import utd_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int BYTE_TARGET = 450;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int HOLD_CYCLES = 60;
	localparam int TAIL_CYCLES = 8;

	// Predicts the decoder byte by byte and keeps the results still owed
	class utf8_scoreboard;
		decode_mode_t          mode;
		logic [REMAIN_W-1:0]   remain;
		logic [CP_W-1:0]       acc;
		result_t               owed_q[$];
		int                    errors;
		int                    decoded;

		function new();
			mode = MODE_IDLE;
			remain = '0;
			acc = '0;
			errors = 0;
			decoded = 0;
		endfunction

		function void add_result(logic [CP_W-1:0] cp, logic bad, logic eos, logic stop);
			result_t r;
			r.code_point = cp;
			r.malformed = bad;
			r.end_of_string = eos;
			r.stopped_early = stop;
			owed_q.insert(owed_q.size(), r);
		endfunction

		function int pending();
			return owed_q.size();
		endfunction

		// Advance the predicted state by one accepted byte
		function void note_byte(logic [BYTE_W-1:0] b);
			if (mode == MODE_HALT) begin
				// drop everything but the terminator
				if (b == BYTE_NUL) begin
					add_result('0, 1'b0, 1'b1, 1'b1);
					mode = MODE_IDLE;
					decoded++;
				end
				return;
			end
			decoded++;
			if (mode == MODE_SEQ) begin
				if (b == BYTE_NUL) begin
					add_result(acc, 1'b1, 1'b0, 1'b0);
					add_result('0, 1'b0, 1'b1, 1'b0);
					mode = MODE_IDLE;
				end else if (b >= BYTE_CONT_LO && b <= BYTE_CONT_HI) begin
					acc = {acc[CP_W-7:0], b[5:0]};
					remain = remain - 1'b1;
					if (remain == '0) begin
						add_result(acc, 1'b0, 1'b0, 1'b0);
						mode = MODE_IDLE;
					end
				end else begin
					add_result(acc, 1'b1, 1'b0, 1'b0);
					mode = MODE_IDLE;
					remain = '0;
				end
				return;
			end
			mode = MODE_IDLE;
			if (b == BYTE_NUL) begin
				add_result('0, 1'b0, 1'b1, 1'b0);
			end else if (b < BYTE_CONT_LO) begin
				add_result({{(CP_W-BYTE_W){1'b0}}, b}, 1'b0, 1'b0, 1'b0);
			end else if (b < BYTE_LEAD2_LO || b > BYTE_LEAD_MAX) begin
				mode = MODE_HALT;
			end else begin
				if (b < BYTE_LEAD3_LO) begin
					acc = CP_W'(b[4:0]);
					remain = 3'd1;
				end else if (b < BYTE_LEAD4_LO) begin
					acc = CP_W'(b[3:0]);
					remain = 3'd2;
				end else if (b < BYTE_LEAD5_LO) begin
					acc = CP_W'(b[2:0]);
					remain = 3'd3;
				end else if (b < BYTE_LEAD6_LO) begin
					acc = CP_W'(b[1:0]);
					remain = 3'd4;
				end else begin
					acc = CP_W'(b[0]);
					remain = 3'd5;
				end
				mode = MODE_SEQ;
			end
		endfunction

		// Compare one delivered result with the oldest owed one
		function void check_result(logic [CP_W-1:0] cp, logic bad, logic eos, logic stop);
			result_t want;
			if (owed_q.size() == 0) begin
				$error("unexpected result: code_point %h malformed %b end_of_string %b stopped_early %b",
					cp, bad, eos, stop);
				errors++;
				return;
			end
			want = owed_q.pop_front();
			if (cp !== want.code_point) begin
				$error("code_point mismatch: expected %h, actual %h", want.code_point, cp);
				errors++;
			end
			if (bad !== want.malformed) begin
				$error("malformed mismatch: expected %b, actual %b", want.malformed, bad);
				errors++;
			end
			if (eos !== want.end_of_string) begin
				$error("end_of_string mismatch: expected %b, actual %b", want.end_of_string, eos);
				errors++;
			end
			if (stop !== want.stopped_early) begin
				$error("stopped_early mismatch: expected %b, actual %b", want.stopped_early, stop);
				errors++;
			end
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_ready;
	logic [BYTE_W-1:0] in_byte;
	logic              out_valid;
	logic              out_ready;
	logic [CP_W-1:0]   code_point;
	logic              malformed;
	logic              end_of_string;
	logic              stopped_early;

	utf8_scoreboard    sb;
	logic [BYTE_W-1:0] str_bytes[$];
	bit                tx_gaps;
	bit                rx_gaps;
	bit                hold_req;
	int                quiet_cycles;

	utf8_to_codepoint_decoder_unit u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.in_byte       (in_byte),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.code_point    (code_point),
		.malformed     (malformed),
		.end_of_string (end_of_string),
		.stopped_early (stopped_early)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// Drive known values on every input from time zero
	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_byte = '0;
		out_ready = 1'b0;
		tx_gaps = 1'b1;
		rx_gaps = 1'b1;
		hold_req = 1'b0;
		sb = new();
	end

	// Lead byte of an n-byte sequence with random payload bits
	function automatic logic [BYTE_W-1:0] lead_byte(int unsigned len);
		case (len)
			2: return BYTE_LEAD2_LO | BYTE_W'($urandom_range(31));
			3: return BYTE_LEAD3_LO | BYTE_W'($urandom_range(15));
			4: return BYTE_LEAD4_LO | BYTE_W'($urandom_range(7));
			5: return BYTE_LEAD5_LO | BYTE_W'($urandom_range(3));
			default: return BYTE_LEAD6_LO | BYTE_W'($urandom_range(1));
		endcase
	endfunction

	function automatic logic [BYTE_W-1:0] cont_byte();
		return BYTE_CONT_LO | BYTE_W'($urandom_range(63));
	endfunction

	// Add one byte at the tail of the string being built
	function automatic void append_byte(logic [BYTE_W-1:0] b);
		str_bytes.insert(str_bytes.size(), b);
	endfunction

	// Offer one byte and hold it until the transaction completes.
	// Enter and leave just after a falling edge.
	task automatic send_byte(input logic [BYTE_W-1:0] b);
		while (tx_gaps && $urandom_range(99) < 27) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_byte <= b;
		do @(posedge clk); while (!in_ready);
		sb.note_byte(b);
		@(negedge clk);
	endtask

	task automatic send_string();
		foreach (str_bytes[i])
			send_byte(str_bytes[i]);
	endtask

	// Build one random zero-terminated string, mostly well formed, with
	// occasional bad continuations, cut-off sequences and bad leads
	task automatic build_string();
		int unsigned nchars;
		int unsigned roll;
		int unsigned len;
		int unsigned k;
		bit          closed;
		nchars = $urandom_range(0, 10);
		closed = 1'b0;
		str_bytes.delete();
		for (int i = 0; i < nchars && !closed; i++) begin
			roll = $urandom_range(99);
			len = $urandom_range(2, 6);
			if (roll < 30) begin
				append_byte(BYTE_W'($urandom_range(1, 127)));
			end else if (roll < 82) begin
				append_byte(lead_byte(len));
				repeat (len - 1) append_byte(cont_byte());
			end else if (roll < 88) begin
				// bad continuation: any nonzero byte outside the continuation range
				append_byte(lead_byte(len));
				k = $urandom_range(0, len - 2);
				repeat (k) append_byte(cont_byte());
				if ($urandom_range(1))
					append_byte(BYTE_W'($urandom_range(1, 127)));
				else
					append_byte(BYTE_W'($urandom_range(192, 255)));
			end else if (roll < 94) begin
				// cut the sequence off with the terminator
				append_byte(lead_byte(len));
				k = $urandom_range(0, len - 2);
				repeat (k) append_byte(cont_byte());
				closed = 1'b1;
			end else begin
				// bad lead, then noise that the decoder must drop
				if ($urandom_range(3) == 0)
					append_byte(BYTE_W'($urandom_range(254, 255)));
				else
					append_byte(BYTE_W'($urandom_range(128, 191)));
				k = $urandom_range(0, 3);
				repeat (k) append_byte(BYTE_W'($urandom_range(1, 255)));
				closed = 1'b1;
			end
		end
		append_byte(BYTE_NUL);
	endtask

	// Receiver: random stalls, gap-free while rx_gaps is low, and one long
	// hold-off on request so the result queue fills and backs up the input
	initial begin
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				repeat (HOLD_CYCLES) begin
					out_ready <= 1'b0;
					@(negedge clk);
				end
			end else begin
				out_ready <= rx_gaps ? ($urandom_range(99) >= 27) : 1'b1;
				@(negedge clk);
			end
		end
	end

	// Check every result transaction at the rising edge
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result(code_point, malformed, end_of_string, stopped_early);
	end

	// Watchdog: count cycles with no transaction on either side
	initial begin
		quiet_cycles = 0;
		while (quiet_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("Regression FAIL");
		$finish;
	end

	// Main sequence
	initial begin
		bit hold_done;
		hold_done = 1'b0;
		#1;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: empty string, ASCII extremes, smallest two-byte and
		// largest six-byte forms
		str_bytes = '{8'h00, 8'h01, 8'h7F, 8'hC0, 8'h80,
			8'hFD, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'h00};
		send_string();
		// Bad lead in the continuation range; the trailing ASCII is dropped
		str_bytes = '{8'h80, 8'h41, 8'h00};
		send_string();
		// Bad continuation, then terminator inside a sequence
		str_bytes = '{8'hE2, 8'h41, 8'hC3, 8'h00};
		send_string();
		// Bad leads at the top of the byte range
		str_bytes = '{8'hFE, 8'h7F, 8'h00, 8'hFF, 8'h00};
		send_string();

		// Random strings
		while (sb.decoded < BYTE_TARGET) begin
			// hold a gap-free stretch in the middle of the run
			tx_gaps = !(sb.decoded >= 150 && sb.decoded < 230);
			rx_gaps = tx_gaps;
			if (!hold_done && sb.decoded >= 300) begin
				hold_req = 1'b1;
				hold_done = 1'b1;
			end
			build_string();
			send_string();
		end
		in_valid <= 1'b0;

		// Drain: wait for every owed result, then let the pipeline settle
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
